/* src/wpre_pkg.sv */
package wpre_pkg;

   localparam int WINDOW      = 32;
   localparam int SAMPLE_BITS = 18;

   localparam int IN_BITS     = 18;
   localparam int FLOOR_BITS  = 18;
   localparam int SCALE_BITS  = 10;
   localparam int LIMIT_BITS  = 8;
   localparam int CSR_DATA_BITS = 18;
   localparam int CSR_IDX_BITS  = 2;
   localparam int BPM_BITS    = 8;
   localparam int CNT_OUT_BITS = 5;
   localparam int CNT_OUT_MAX  = 31;

   localparam int PTR_BITS  = $clog2(WINDOW);
   localparam int CNT_BITS  = $clog2(WINDOW + 1);
   localparam int PROD_BITS = CNT_BITS + SCALE_BITS;
   // x / 10 as (x * 0xCCCC) >> 19 undershoots by at most one for x < 2^19
   localparam int DIV_MUL_BITS = 16;
   localparam int DIV_SHIFT    = 19;
   localparam logic [DIV_MUL_BITS-1:0] DIV_MUL = 16'hCCCC;
   localparam int Q_BITS       = PROD_BITS - 3;
   localparam int DIVISOR      = 10;

   // largest count a window can produce, as seen on the result port
   localparam int CNT_WIN_MAX  = (WINDOW + 1) / 2;
   localparam int CNT_PORT_MAX = (CNT_WIN_MAX > CNT_OUT_MAX) ? CNT_OUT_MAX : CNT_WIN_MAX;

   localparam logic [FLOOR_BITS-1:0] FLOOR_RST = 18'd500;
   localparam logic [SCALE_BITS-1:0] SCALE_RST = 10'd187;
   localparam logic [LIMIT_BITS-1:0] LOW_RST   = 8'd40;
   localparam logic [LIMIT_BITS-1:0] HIGH_RST  = 8'd200;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_AMP_FLOOR  = 2'd0,
      CSR_RATE_SCALE = 2'd1,
      CSR_RATE_LOW   = 2'd2,
      CSR_RATE_HIGH  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FLOOR_BITS-1:0] amp_floor;
      logic [SCALE_BITS-1:0] rate_scale;
      logic [LIMIT_BITS-1:0] rate_low;
      logic [LIMIT_BITS-1:0] rate_high;
   } cfg_type;

   typedef struct packed {
      logic fill_wr;
      logic thr_load;
      logic scan_step;
      logic mul;
      logic div;
      logic corr;
      logic chk;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic scan_last;
      logic amp_ok;
   } status_type;

endpackage

/* src/wpre_ctrl.sv */
module wpre_ctrl import wpre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_FILL  = 8'b0000_0001,
      ST_THR   = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_DRAIN = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_CORR  = 8'b0100_0000,
      ST_CHK   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_FILL: begin
            if (start) begin
               cmd.fill_wr = 1'b1;
               if (status.fill_last) state_in = ST_THR;
            end
         end
         ST_THR: begin
            cmd.thr_load = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            // low swing: no scan, count stays zero
            if (!status.amp_ok) begin
               state_in = ST_MUL;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_CORR;
         end
         ST_CORR: begin
            cmd.corr = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.chk  = 1'b1;
            state_in = ST_FILL;
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_FILL;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_FILL);

endmodule

/* src/wpre_dp.sv */
module wpre_dp import wpre_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  cfg_type                 cfg,
   input  logic [IN_BITS-1:0]      req_sample,
   output logic                    rsp_strobe,
   output logic [BPM_BITS-1:0]     rsp_rate_bpm,
   output logic                    rsp_rate_valid,
   output logic [CNT_OUT_BITS-1:0] rsp_crossing_count
);

   logic [SAMPLE_BITS-1:0] mem [WINDOW];

   logic [SAMPLE_BITS-1:0] sample;
   logic [PTR_BITS-1:0]    fill_ptr_ff, fill_ptr_in;
   logic [PTR_BITS-1:0]    scan_ptr_ff, scan_ptr_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] span;
   logic [SAMPLE_BITS-1:0] thr_ff, thr_in;
   logic                   amp_ok_ff, amp_ok_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rd_vld_ff;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   above_ff, above_in;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [PROD_BITS+DIV_MUL_BITS-1:0] recip_prod;
   logic [Q_BITS-1:0]      q0_ff;
   logic [PROD_BITS-1:0]   rem;
   logic [Q_BITS-1:0]      q_ff, q_in;
   logic                   bpm_ok;
   logic                   strobe_ff;
   logic [BPM_BITS-1:0]    bpm_ff;
   logic                   valid_ff;
   logic [CNT_OUT_BITS-1:0] cnt_out_ff;

   assign sample = req_sample[SAMPLE_BITS-1:0];

   // fill side: store, min/max, write pointer
   always_comb begin
      fill_ptr_in = fill_ptr_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      if (cmd.thr_load) begin
         fill_ptr_in = '0;
         min_in      = '1;
         max_in      = '0;
      end else if (cmd.fill_wr) begin
         fill_ptr_in = fill_ptr_ff + PTR_BITS'(1);
         if (sample < min_ff) min_in = sample;
         if (sample > max_ff) max_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_wr) mem[fill_ptr_ff] <= sample;
      if (cmd.scan_step) rd_data_ff <= mem[scan_ptr_ff];
   end

   assign span      = max_ff - min_ff;
   assign amp_ok_in = cmd.thr_load ? (span >= cfg.amp_floor) : amp_ok_ff;
   assign thr_in    = cmd.thr_load ? (min_ff + (span >> 1)) : thr_ff;

   // crossing scan, one stored sample per cycle
   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      count_in    = count_ff;
      above_in    = above_ff;
      if (cmd.thr_load) begin
         scan_ptr_in = '0;
         count_in    = '0;
         above_in    = 1'b0;
      end else begin
         if (cmd.scan_step) scan_ptr_in = scan_ptr_ff + PTR_BITS'(1);
         if (rd_vld_ff) begin
            if (!above_ff && (rd_data_ff > thr_ff)) begin
               count_in = count_ff + CNT_BITS'(1);
               above_in = 1'b1;
            end else if (rd_data_ff < thr_ff) begin
               above_in = 1'b0;
            end
         end
      end
   end

   // rate = count * scale / 10
   assign recip_prod = (PROD_BITS + DIV_MUL_BITS)'(prod_ff) *
                       (PROD_BITS + DIV_MUL_BITS)'(DIV_MUL);
   assign rem  = prod_ff - PROD_BITS'(q0_ff) * PROD_BITS'(DIVISOR);
   assign q_in = (rem >= PROD_BITS'(DIVISOR)) ? q0_ff + Q_BITS'(1) : q0_ff;
   assign bpm_ok = (q_ff >= Q_BITS'(cfg.rate_low)) && (q_ff <= Q_BITS'(cfg.rate_high));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ptr_ff <= '0;
         scan_ptr_ff <= '0;
         min_ff      <= '1;
         max_ff      <= '0;
         amp_ok_ff   <= 1'b0;
         rd_vld_ff   <= 1'b0;
         count_ff    <= '0;
         above_ff    <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         fill_ptr_ff <= fill_ptr_in;
         scan_ptr_ff <= scan_ptr_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         amp_ok_ff   <= amp_ok_in;
         rd_vld_ff   <= cmd.scan_step;
         count_ff    <= count_in;
         above_ff    <= above_in;
         strobe_ff   <= cmd.chk;
      end
   end

   always_ff @(posedge clock) begin
      thr_ff <= thr_in;
      if (cmd.mul)  prod_ff <= PROD_BITS'(count_ff) * PROD_BITS'(cfg.rate_scale);
      if (cmd.div)  q0_ff   <= recip_prod[PROD_BITS+DIV_MUL_BITS-1:DIV_SHIFT];
      if (cmd.corr) q_ff    <= q_in;
      if (cmd.chk) begin
         valid_ff <= amp_ok_ff && bpm_ok;
         bpm_ff   <= (amp_ok_ff && bpm_ok) ? q_ff[BPM_BITS-1:0] : '0;
         if (32'(count_ff) > 32'(CNT_OUT_MAX)) cnt_out_ff <= CNT_OUT_BITS'(CNT_OUT_MAX);
         else                                  cnt_out_ff <= CNT_OUT_BITS'(count_ff);
      end
   end

   assign status.fill_last = (fill_ptr_ff == PTR_BITS'(WINDOW - 1));
   assign status.scan_last = (scan_ptr_ff == PTR_BITS'(WINDOW - 1));
   assign status.amp_ok    = amp_ok_ff;

   assign rsp_strobe         = strobe_ff;
   assign rsp_rate_bpm       = bpm_ff;
   assign rsp_rate_valid     = valid_ff;
   assign rsp_crossing_count = cnt_out_ff;

endmodule

/* src/window_pulse_rate_estimator.sv */
// Windowed pulse rate estimator.
// Request channel: an optical sample on req_sample is taken at a rising edge
// with start high and busy low. Samples may come one per cycle while a window
// fills; only the low SAMPLE_BITS bits are kept.
// After the WINDOW-th sample busy goes high. The block forms the threshold,
// scans the stored window one entry per cycle through the sample memory's
// read port, then runs the multiply and divide-by-ten steps. rsp_strobe is
// high for one cycle, after the threshold, scan, drain, multiply, divide,
// correction and check states (scan and drain are skipped when the swing is
// below the floor); busy drops in that same cycle. No new sample is taken
// until the window is through; the scan uses the single memory read port.
// Result ports hold their value after the strobe; the receiver cannot stall
// and must take the result in the strobe cycle.
// csr_we writes register csr_index (floor, scale, low limit, high limit)
// at once; write only while idle. Reset restores the default registers and
// starts an empty window; the sample memory needs no clearing.
module window_pulse_rate_estimator import wpre_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [IN_BITS-1:0]       req_sample,
   output logic                     rsp_strobe,
   output logic [BPM_BITS-1:0]      rsp_rate_bpm,
   output logic                     rsp_rate_valid,
   output logic [CNT_OUT_BITS-1:0]  rsp_crossing_count,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_AMP_FLOOR:  cfg_in.amp_floor  = csr_wdata[FLOOR_BITS-1:0];
            CSR_RATE_SCALE: cfg_in.rate_scale = csr_wdata[SCALE_BITS-1:0];
            CSR_RATE_LOW:   cfg_in.rate_low   = csr_wdata[LIMIT_BITS-1:0];
            CSR_RATE_HIGH:  cfg_in.rate_high  = csr_wdata[LIMIT_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.amp_floor  <= FLOOR_RST;
         cfg_ff.rate_scale <= SCALE_RST;
         cfg_ff.rate_low   <= LOW_RST;
         cfg_ff.rate_high  <= HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wpre_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   wpre_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg_ff),
      .req_sample         (req_sample),
      .rsp_strobe         (rsp_strobe),
      .rsp_rate_bpm       (rsp_rate_bpm),
      .rsp_rate_valid     (rsp_rate_valid),
      .rsp_crossing_count (rsp_crossing_count)
   );

endmodule

/* src/wpre_checker.sv */
module wpre_checker import wpre_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic [BPM_BITS-1:0]      rsp_rate_bpm,
   input logic                     rsp_rate_valid,
   input logic [CNT_OUT_BITS-1:0]  rsp_crossing_count
);

   // a result closes a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without preceding busy period");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_rate_valid) |-> (rsp_rate_bpm == '0))
      else $error("invalid result with nonzero rate");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_crossing_count) <= 32'(CNT_PORT_MAX)))
      else $error("crossing count beyond window limit");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy raised without an accepted request");

endmodule

bind window_pulse_rate_estimator wpre_checker u_wpre_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import wpre_pkg::*;

   localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
   localparam int RAND_WINDOWS = 37;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [BPM_BITS-1:0]     bpm;
      logic                    valid;
      logic [CNT_OUT_BITS-1:0] count;
   } pulse_result_type;

   typedef enum logic [2:0] {
      PAT_FLAT, PAT_SQUARE, PAT_TRI, PAT_HOLD, PAT_RAMP, PAT_NOISE, PAT_JITTER
   } wave_kind_type;

   typedef struct packed {
      bit                    wr_cfg;
      logic [FLOOR_BITS-1:0] amp_floor;
      logic [SCALE_BITS-1:0] scale;
      logic [LIMIT_BITS-1:0] low_lim;
      logic [LIMIT_BITS-1:0] high_lim;
      wave_kind_type         wave;
      logic [IN_BITS-1:0]    lo;
      logic [IN_BITS-1:0]    hi;
      logic [5:0]            period;
      bit                    typed;
      pulse_result_type      want;
   } dir_row_type;

   // one row per window; typed rows carry a result that is obvious by hand
   localparam dir_row_type DIR_ROWS [19] = '{
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_FLAT, 18'd0, 18'd0, 6'd2,
        1'b1, '{8'd0, 1'b0, 5'd0}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_FLAT, 18'd262143, 18'd262143, 6'd2,
        1'b1, '{8'd0, 1'b0, 5'd0}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_SQUARE, 18'd0, 18'd262143, 6'd2,
        1'b1, '{8'd0, 1'b0, 5'd16}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_SQUARE, 18'd0, 18'd262143, 6'd4,
        1'b1, '{8'd149, 1'b1, 5'd8}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_SQUARE, 18'd1000, 18'd1499, 6'd4,
        1'b1, '{8'd0, 1'b0, 5'd0}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_SQUARE, 18'd1000, 18'd1500, 6'd4,
        1'b1, '{8'd149, 1'b1, 5'd8}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_SQUARE, 18'd0, 18'd262143, 6'd16,
        1'b1, '{8'd0, 1'b0, 5'd2}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_TRI, 18'd0, 18'd1000, 6'd4,
        1'b0, '{8'd0, 1'b0, 5'd0}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_HOLD, 18'd5000, 18'd9000, 6'd2,
        1'b0, '{8'd0, 1'b0, 5'd0}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_RAMP, 18'd0, 18'd262143, 6'd2,
        1'b0, '{8'd0, 1'b0, 5'd0}},
      '{1'b0, 18'd500, 10'd187, 8'd40, 8'd200, PAT_NOISE, 18'd0, 18'd262143, 6'd2,
        1'b0, '{8'd0, 1'b0, 5'd0}},
      '{1'b1, 18'd0, 10'd187, 8'd0, 8'd255, PAT_FLAT, 18'd12345, 18'd12345, 6'd2,
        1'b1, '{8'd0, 1'b1, 5'd0}},
      '{1'b1, 18'd262143, 10'd1023, 8'd0, 8'd255, PAT_SQUARE, 18'd0, 18'd262143, 6'd32,
        1'b1, '{8'd102, 1'b1, 5'd1}},
      '{1'b0, 18'd262143, 10'd1023, 8'd0, 8'd255, PAT_SQUARE, 18'd1, 18'd262143, 6'd32,
        1'b1, '{8'd0, 1'b0, 5'd0}},
      '{1'b1, 18'd0, 10'd0, 8'd0, 8'd0, PAT_SQUARE, 18'd0, 18'd262143, 6'd2,
        1'b1, '{8'd0, 1'b1, 5'd16}},
      '{1'b1, 18'd0, 10'd1023, 8'd255, 8'd255, PAT_SQUARE, 18'd0, 18'd262143, 6'd2,
        1'b1, '{8'd0, 1'b0, 5'd16}},
      '{1'b1, 18'd100, 10'd100, 8'd200, 8'd100, PAT_SQUARE, 18'd0, 18'd262143, 6'd4,
        1'b1, '{8'd0, 1'b0, 5'd8}},
      '{1'b1, 18'd100, 10'd125, 8'd100, 8'd100, PAT_SQUARE, 18'd0, 18'd262143, 6'd4,
        1'b1, '{8'd100, 1'b1, 5'd8}},
      '{1'b1, 18'd300, 10'd500, 8'd50, 8'd250, PAT_JITTER, 18'd20000, 18'd60000, 6'd8,
        1'b0, '{8'd0, 1'b0, 5'd0}}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [IN_BITS-1:0]       req_sample = '0;
   logic                     rsp_strobe;
   logic [BPM_BITS-1:0]      rsp_rate_bpm;
   logic                     rsp_rate_valid;
   logic [CNT_OUT_BITS-1:0]  rsp_crossing_count;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_AMP_FLOOR;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   window_pulse_rate_estimator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_sample         (req_sample),
      .rsp_strobe         (rsp_strobe),
      .rsp_rate_bpm       (rsp_rate_bpm),
      .rsp_rate_valid     (rsp_rate_valid),
      .rsp_crossing_count (rsp_crossing_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state: register copies and the window being collected
   logic [FLOOR_BITS-1:0]  cur_floor = FLOOR_RST;
   logic [SCALE_BITS-1:0]  cur_scale = SCALE_RST;
   logic [LIMIT_BITS-1:0]  cur_low   = LOW_RST;
   logic [LIMIT_BITS-1:0]  cur_high  = HIGH_RST;
   logic [SAMPLE_BITS-1:0] win_store [WINDOW];
   int unsigned            win_fill  = 0;
   logic [SAMPLE_BITS-1:0] win_lo    = '1;
   logic [SAMPLE_BITS-1:0] win_hi    = '0;

   pulse_result_type       pending_rates [$];
   pulse_result_type       rate_head;
   logic [IN_BITS-1:0]     wave_buf [WINDOW];
   bit                     idle_on = 1'b1;
   int                     mismatch_count = 0;
   int                     results_checked = 0;
   int                     samples_sent = 0;
   int                     windows_sent = 0;
   int                     cfg_phases = 0;
   int                     cycle_count = 0;

   task automatic track_sample(input logic [IN_BITS-1:0] s, output bit done,
                               output pulse_result_type r);
      logic [SAMPLE_BITS-1:0] v;
      int unsigned span, thr, n, bpm;
      bit above, ok;
      v = s[SAMPLE_BITS-1:0];
      done = 1'b0;
      r = '0;
      win_store[win_fill] = v;
      if (v < win_lo) win_lo = v;
      if (v > win_hi) win_hi = v;
      win_fill++;
      if (win_fill == WINDOW) begin
         span = win_hi - win_lo;
         n = 0;
         bpm = 0;
         ok = 1'b0;
         if (span >= cur_floor) begin
            thr = win_lo + span / 2;
            above = 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
               if (!above && win_store[i] > thr) begin
                  n++;
                  above = 1'b1;
               end else if (win_store[i] < thr) begin
                  above = 1'b0;
               end
            end
            bpm = (n * cur_scale) / DIVISOR;
            ok = (bpm >= cur_low) && (bpm <= cur_high);
         end
         r.bpm   = ok ? bpm[BPM_BITS-1:0] : '0;
         r.valid = ok;
         r.count = (n > CNT_OUT_MAX) ? CNT_OUT_BITS'(CNT_OUT_MAX) : CNT_OUT_BITS'(n);
         done = 1'b1;
         win_fill = 0;
         win_lo = '1;
         win_hi = '0;
      end
   endtask

   task automatic build_window(input wave_kind_type wave, input int lo, input int hi,
                               input int period);
      int mid, jit, v;
      mid = lo + (hi - lo) / 2;
      jit = (hi - lo) / 8;
      for (int i = 0; i < WINDOW; i++) begin
         case (wave)
            PAT_FLAT:   v = lo;
            PAT_SQUARE: v = ((i % period) < period / 2) ? lo : hi;
            // middle level sits exactly on the threshold
            PAT_TRI:    v = (i % 4 == 0) ? lo : (i % 4 == 2) ? hi : mid;
            PAT_HOLD:   v = (i % 2 == 0) ? hi : mid;
            PAT_RAMP:   v = lo + int'((longint'(hi - lo) * i) / (WINDOW - 1));
            PAT_NOISE:  v = $urandom_range(hi, lo);
            default: begin
               v = ((i % period) < period / 2) ? lo : hi;
               v = v + int'($urandom_range(2 * jit, 0)) - jit;
               if (v < 0) v = 0;
               if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            end
         endcase
         wave_buf[i] = IN_BITS'(v);
      end
   endtask

   // enters and leaves at a falling edge; start gets one assignment per edge
   task automatic send_sample(input logic [IN_BITS-1:0] s, output bit done,
                              output pulse_result_type r);
      while (idle_on && $urandom_range(99) < 22) begin
         start <= 1'b0;
         req_sample <= IN_BITS'($urandom);
         @(negedge clock);
      end
      start <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
      track_sample(s, done, r);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_window(input bit typed, input pulse_result_type want);
      bit done;
      pulse_result_type got;
      for (int i = 0; i < WINDOW; i++) begin
         send_sample(wave_buf[i], done, got);
         if (done) pending_rates.push_back(typed ? want : got);
      end
      windows_sent++;
   endtask

   task automatic wait_results();
      start <= 1'b0;
      while (pending_rates.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // upper data bits of the narrow registers carry junk that must be dropped
   task automatic program_config(input logic [FLOOR_BITS-1:0] amp_floor,
                                 input logic [SCALE_BITS-1:0] scale,
                                 input logic [LIMIT_BITS-1:0] low_lim,
                                 input logic [LIMIT_BITS-1:0] high_lim);
      csr_index_type idx;
      logic [CSR_DATA_BITS-1:0] wd;
      idx = idx.first();
      repeat (4) begin
         wd = CSR_DATA_BITS'($urandom);
         case (idx)
            CSR_AMP_FLOOR:  wd = amp_floor;
            CSR_RATE_SCALE: wd[SCALE_BITS-1:0] = scale;
            CSR_RATE_LOW:   wd[LIMIT_BITS-1:0] = low_lim;
            default:        wd[LIMIT_BITS-1:0] = high_lim;
         endcase
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= wd;
         @(negedge clock);
         idx = idx.next();
      end
      csr_we <= 1'b0;
      @(negedge clock);
      cur_floor = amp_floor;
      cur_scale = scale;
      cur_low   = low_lim;
      cur_high  = high_lim;
      cfg_phases++;
   endtask

   task automatic random_config();
      int f, s, l, h;
      case ($urandom_range(9))
         0:       f = 0;
         1:       f = SAMPLE_MAX;
         2, 3, 4: f = $urandom_range(2000, 0);
         default: f = $urandom_range(50000, 0);
      endcase
      case ($urandom_range(9))
         0:       s = 0;
         1:       s = (1 << SCALE_BITS) - 1;
         default: s = $urandom_range(400, 50);
      endcase
      case ($urandom_range(9))
         0:       l = 0;
         1:       l = 255;
         default: l = $urandom_range(80, 0);
      endcase
      case ($urandom_range(9))
         0:       h = 255;
         1:       h = 0;
         default: h = $urandom_range(255, 120);
      endcase
      program_config(FLOOR_BITS'(f), SCALE_BITS'(s), LIMIT_BITS'(l), LIMIT_BITS'(h));
   endtask

   task automatic random_window();
      int lo, amp;
      wave_kind_type wave;
      case ($urandom_range(9))
         0:       wave = PAT_FLAT;
         1:       wave = PAT_RAMP;
         2:       wave = PAT_NOISE;
         3:       wave = PAT_HOLD;
         4, 5:    wave = PAT_TRI;
         6, 7:    wave = PAT_SQUARE;
         default: wave = PAT_JITTER;
      endcase
      case ($urandom_range(3))
         0:       amp = $urandom_range(1500, 0);
         1:       amp = $urandom_range(20000, 0);
         default: amp = $urandom_range(SAMPLE_MAX, 0);
      endcase
      lo = $urandom_range(SAMPLE_MAX - amp, 0);
      build_window(wave, lo, lo + amp, $urandom_range(32, 2));
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rates.size() == 0) begin
            $display("%0t: unexpected result, expected none, got bpm %0d valid %0d count %0d",
                     $time, rsp_rate_bpm, rsp_rate_valid, rsp_crossing_count);
            mismatch_count++;
         end else begin
            rate_head = pending_rates.pop_front();
            check_field("rate_bpm", rate_head.bpm, rsp_rate_bpm);
            check_field("rate_valid", rate_head.valid, rsp_rate_valid);
            check_field("crossing_count", rate_head.count, rsp_crossing_count);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, pending_rates.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIR_ROWS[r]) begin
         if (DIR_ROWS[r].wr_cfg) begin
            wait_results();
            program_config(DIR_ROWS[r].amp_floor, DIR_ROWS[r].scale,
                           DIR_ROWS[r].low_lim, DIR_ROWS[r].high_lim);
         end
         build_window(DIR_ROWS[r].wave, DIR_ROWS[r].lo, DIR_ROWS[r].hi,
                      DIR_ROWS[r].period);
         send_window(DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end

      for (int w = 0; w < RAND_WINDOWS; w++) begin
         // back-to-back requests for a stretch of windows
         idle_on = !(w >= 10 && w < 25);
         if (w == 0 || $urandom_range(4) == 0) begin
            wait_results();
            random_config();
         end
         random_window();
         send_window(1'b0, '0);
      end

      start <= 1'b0;
      while (pending_rates.size() != 0) @(negedge clock);
      repeat (WINDOW + 10) @(negedge clock);

      $display("Sent %0d windows (%0d samples) over %0d register settings;",
               windows_sent, samples_sent, cfg_phases + 1);
      $display("checked %0d rate results, %0d mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
src/wpre_pkg.sv
src/wpre_ctrl.sv
src/wpre_dp.sv
src/window_pulse_rate_estimator.sv
src/wpre_checker.sv
bench/tb_top.sv
